// ===== design/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i2cws_pkg.sv =====
// Shared types and constants for the I2C write sequencer.
// No dependencies; used by the step engine and the top level.
package i2cws_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  // Byte constants
  localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_COMMAND   = 8'h00;
  localparam logic [7:0] CTRL_DATA      = 8'h40;

  // Sequencer phases
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_BYTE  = 4'b0100,
    ST_STOP  = 4'b1000
  } seq_state_t;

  // Input item as held in the input register
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] payload;
    logic       sda_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic ack_missing;
    logic request_refused;
  } out_item_t;

endpackage

// ===== design/i2cws_in_if.sv =====
// Input channel of the I2C write sequencer: valid/ready plus item fields.
// Depends on nothing beyond the field widths fixed here.
interface i2cws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] payload;
  logic       sda_in;

  modport source (output valid, output op, output payload, output sda_in, input ready);
  modport sink   (input valid, input op, input payload, input sda_in, output ready);
endinterface

// ===== design/i2cws_out_if.sv =====
// Result channel of the I2C write sequencer: valid/ready plus pin and status fields.
// Depends on nothing beyond the field widths fixed here.
interface i2cws_out_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;
  logic busy_res;
  logic ack_missing;
  logic request_refused;

  modport source (output valid, output scl_level, output sda_level, output busy_res,
                  output ack_missing, output request_refused, input ready);
  modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                  input ack_missing, input request_refused, output ready);
endinterface

// ===== design/i2cws_step.sv =====
// Step engine: sequencer state, pin registers and one pin action per transaction.
// Depends on i2cws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cws_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  i2cws_pkg::in_item_t  item,
  input  logic [7:0]           dev_addr,
  output i2cws_pkg::out_item_t res
);

  // Slot numbers within one byte
  localparam logic [4:0] J_FIRST    = 5'd0;
  localparam logic [4:0] J_BITS_END = 5'd24;
  localparam logic [4:0] J_LOW_A    = 5'd24;
  localparam logic [4:0] J_LOW_B    = 5'd25;
  localparam logic [4:0] J_RELEASE  = 5'd26;
  localparam logic [4:0] J_ACK_HIGH = 5'd27;
  localparam logic [4:0] J_ACK_SAMP = 5'd28;
  // Start/stop step numbers
  localparam logic [4:0] J_ONE      = 5'd1;
  localparam logic [4:0] J_TWO      = 5'd2;
  // Bit phases
  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  // Byte indexes
  localparam logic [1:0] B_ADDR = 2'd0;
  localparam logic [1:0] B_CTRL = 2'd1;
  localparam logic [1:0] B_LAST = 2'd2;

  i2cws_pkg::seq_state_t state_r, state_nxt;
  logic [4:0] j_r, j_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [1:0] b_r, b_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       data_r, data_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic       refused;
  logic       is_start;
  logic [7:0] cur_byte;

  assign is_start = (item.op == i2cws_pkg::OP_CMD) || (item.op == i2cws_pkg::OP_DATA);

  // Byte to shift out for the current byte index
  always_comb begin
    priority if (b_r == B_ADDR) begin
      cur_byte = dev_addr;
    end else if (b_r == B_CTRL) begin
      cur_byte = data_r ? i2cws_pkg::CTRL_DATA : i2cws_pkg::CTRL_COMMAND;
    end else begin
      cur_byte = hold_r;
    end
  end

  // One pin action per transaction
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    ph_nxt    = ph_r;
    b_nxt     = b_r;
    hold_nxt  = hold_r;
    data_nxt  = data_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    refused   = 1'b0;
    unique case (state_r)
      i2cws_pkg::ST_IDLE: begin
        if (is_start) begin
          hold_nxt  = item.payload;
          data_nxt  = (item.op == i2cws_pkg::OP_DATA);
          scl_nxt   = 1'b1;
          state_nxt = i2cws_pkg::ST_START;
          j_nxt     = J_ONE;
        end
      end
      i2cws_pkg::ST_START: begin
        refused = is_start;
        priority if (j_r == J_ONE) begin
          sda_nxt = 1'b1;
          j_nxt   = j_r + 5'd1;
        end else if (j_r == J_TWO) begin
          sda_nxt = 1'b0;
          j_nxt   = j_r + 5'd1;
        end else begin
          scl_nxt   = 1'b0;
          state_nxt = i2cws_pkg::ST_BYTE;
          j_nxt     = J_FIRST;
          ph_nxt    = PH_LOW;
          b_nxt     = B_ADDR;
        end
      end
      i2cws_pkg::ST_BYTE: begin
        refused = is_start;
        if (j_r < J_BITS_END) begin
          // low / set bit / high triples, MSB first
          if (j_r == J_FIRST) shift_nxt = cur_byte;
          unique case (ph_r)
            PH_LOW:  scl_nxt = 1'b0;
            PH_DATA: begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
            end
            PH_HIGH: scl_nxt = 1'b1;
            default: ;
          endcase
          ph_nxt = (ph_r == PH_HIGH) ? PH_LOW : ph_r + 2'd1;
          j_nxt  = j_r + 5'd1;
        end else if (j_r == J_LOW_A || j_r == J_LOW_B) begin
          scl_nxt = 1'b0;
          j_nxt   = j_r + 5'd1;
        end else if (j_r == J_RELEASE) begin
          sda_nxt = 1'b1;
          j_nxt   = j_r + 5'd1;
        end else if (j_r == J_ACK_HIGH) begin
          scl_nxt = 1'b1;
          j_nxt   = j_r + 5'd1;
        end else if (j_r == J_ACK_SAMP) begin
          // sample acknowledge, close the slot
          ack_nxt = item.sda_in;
          scl_nxt = 1'b0;
          j_nxt   = J_FIRST;
          ph_nxt  = PH_LOW;
          if (b_r == B_LAST) begin
            state_nxt = i2cws_pkg::ST_STOP;
          end else begin
            b_nxt = b_r + 2'd1;
          end
        end
      end
      i2cws_pkg::ST_STOP: begin
        refused = is_start;
        priority if (j_r == J_FIRST) begin
          sda_nxt = 1'b0;
          j_nxt   = j_r + 5'd1;
        end else if (j_r == J_ONE) begin
          scl_nxt = 1'b1;
          j_nxt   = j_r + 5'd1;
        end else begin
          sda_nxt   = 1'b1;
          state_nxt = i2cws_pkg::ST_IDLE;
          j_nxt     = J_FIRST;
        end
      end
      default: state_nxt = i2cws_pkg::ST_IDLE;
    endcase
  end

  // Result of this step
  always_comb begin
    res.scl_level       = scl_nxt;
    res.sda_level       = sda_nxt;
    res.busy_res        = (state_nxt != i2cws_pkg::ST_IDLE);
    res.ack_missing     = ack_nxt;
    res.request_refused = refused;
  end

  // State registers, updated once per consumed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2cws_pkg::ST_IDLE;
      j_r     <= 5'd0;
      ph_r    <= PH_LOW;
      b_r     <= B_ADDR;
      hold_r  <= 8'd0;
      data_r  <= 1'b0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      ph_r    <= ph_nxt;
      b_r     <= b_nxt;
      hold_r  <= hold_nxt;
      data_r  <= data_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
    end
  end

  `ASSERT_SAME(a_ph_range, state_r == i2cws_pkg::ST_BYTE, ph_r != 2'd3, "bit phase out of range")
  `ASSERT_NEXT(a_stop_done, advance && state_r == i2cws_pkg::ST_STOP && j_r == J_TWO, state_r == i2cws_pkg::ST_IDLE && sda_r && scl_r, "stop did not end idle with lines high")
  `ASSERT_NEXT(a_ack_sample, advance && state_r == i2cws_pkg::ST_BYTE && j_r == J_ACK_SAMP, ack_r == $past(item.sda_in), "acknowledge not captured")

endmodule

// ===== design/i2c_write_sequencer.sv =====
// I2C write sequencer: each accepted transaction advances the bus by one pin step, in
// order, through start, address byte, control byte (0x00 command, 0x40 data), payload
// byte with acknowledge slots, and stop: 94 steps per write. Op 1 or 2 starts a write
// when idle; other transactions are ticks. One result per input, through the input register
// and then the result register, at one transaction per clock while out_ch.ready does not
// stall the result register; the step engine's next-state logic is combinational. A start
// request while busy is flagged and treated as a tick. A missing acknowledge is
// reported and stays set until the next acknowledge slot.
// Depends on i2cws_pkg, the channel interfaces, i2cws_step and assert_macros.svh.
`include "assert_macros.svh"

module i2c_write_sequencer (
  input  logic         clk,
  input  logic         rst_n,
  i2cws_in_if.sink     in_ch,
  i2cws_out_if.source  out_ch,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  logic [7:0]           dev_addr_r;
  i2cws_pkg::in_item_t  in_r;
  logic                 in_valid_r;
  i2cws_pkg::out_item_t out_r;
  logic                 out_valid_r;
  i2cws_pkg::out_item_t res;
  logic                 advance;

  // Move the held transaction into the result register when there is room
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Device address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cws_pkg::DEV_ADDR_RESET;
    end else if (cfg_wr_en) begin
      dev_addr_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r.op      <= in_ch.op;
      in_r.payload <= in_ch.payload;
      in_r.sda_in  <= in_ch.sda_in;
    end
  end

  i2cws_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (in_r),
    .dev_addr (dev_addr_r),
    .res      (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_r <= res;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.scl_level       = out_r.scl_level;
  assign out_ch.sda_level       = out_r.sda_level;
  assign out_ch.busy_res        = out_r.busy_res;
  assign out_ch.ack_missing     = out_r.ack_missing;
  assign out_ch.request_refused = out_r.request_refused;

  `ASSERT_NEXT(a_in_hold, in_valid_r && out_valid_r && !out_ch.ready, in_valid_r, "held transaction dropped under stall")

endmodule
